// File: design/sab_pkg.sv
// shared constants, codes and types of the suffix automaton builder
package sab_pkg;

  localparam int MAX_LEN_DEF    = 256;
  localparam int MAX_STATES_DEF = 512;
  localparam int ALPHA          = 256;
  localparam int SYM_W          = 8;
  localparam int IDX_W          = 9;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    FUNC_RESET    = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_TRAVERSE = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LEN, S_CLR, S_W1, S_W2, S_W3, S_Q1, S_Q2, S_Q3,
    S_CP, S_R1, S_R2, S_R3, S_L1, S_L2, S_TR, S_TG1, S_DONE
  } state_t;

endpackage

// File: design/sab_ram.sv
// generic simple dual port ram with registered read
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/suffix_automaton_builder.sv
// suffix automaton builder: online construction over byte symbols
// traverse reads one transition from start_state; a reset request clears the root row again
// append sets the new state's length and first position, clears its row, then walks the suffix
// links setting transitions until the root or an existing transition; a clone copies q's row
// and redirects along the links; an append is refused when full; one request at a time
// rst clears the root row, during which no request is taken
module suffix_automaton_builder #(
  parameter int MAX_LEN    = sab_pkg::MAX_LEN_DEF,
  parameter int MAX_STATES = sab_pkg::MAX_STATES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // symbol[7:0], start_state[16:8]
  input  logic [sab_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[1:0]
  input  logic [sab_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // next_state[8:0], target_len[17:9], target_first_pos[25:18], chars_added[34:26],
  // states_created[43:35]
  output logic [sab_pkg::OUT_DATA_W-1:0] m_tdata,
  // full_res[0]
  output logic [sab_pkg::OUT_USER_W-1:0] m_tuser
);

  import sab_pkg::*;

  localparam int SW = $clog2(MAX_STATES);
  localparam int CW = $clog2(MAX_STATES + 1);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int FW = $clog2(MAX_LEN);
  localparam int TW = SW + SYM_W;

  state_t state, state_next;

  logic [CW-1:0]    count;
  logic [LW-1:0]    symcount;
  logic [SW-1:0]    last, cur, p, q, cl, tgt;
  logic [SYM_W-1:0] c;
  logic [8:0]       start;
  logic [IDX_W-1:0] idx;
  logic [LW-1:0]    len_last, lenp;
  logic             pend, full;

  logic           t_we, l_we, k_we, f_we;
  logic [TW-1:0]  t_waddr, t_raddr;
  logic [SW-1:0]  t_wdata, t_rdata;
  logic [SW-1:0]  l_waddr, l_raddr, k_waddr, k_raddr, f_waddr, f_raddr;
  logic [LW-1:0]  l_wdata, l_rdata;
  logic [SW-1:0]  k_wdata, k_rdata;
  logic [FW-1:0]  f_wdata, f_rdata;

  func_t          in_func;
  logic           in_ok, is_full, out_free;

  assign in_func  = func_t'(s_tuser[1:0]);
  assign s_tready = (state == S_IDLE);
  assign in_ok    = s_tvalid && s_tready;
  assign is_full  = (symcount >= LW'(MAX_LEN)) || ((32'(count) + 2) > MAX_STATES);
  assign out_free = !m_tvalid || m_tready;

  sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES * ALPHA)) u_trans (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );
  sab_ram #(.WIDTH(LW), .DEPTH(MAX_STATES)) u_len (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );
  sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_link (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );
  sab_ram #(.WIDTH(FW), .DEPTH(MAX_STATES)) u_fpos (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    t_we = 1'b0; t_waddr = {p, c}; t_wdata = '0; t_raddr = {p, c};
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = tgt;
    k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = p;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = tgt;
    case (state)
      S_INIT: begin
        t_we = 1'b1; t_waddr = {SW'(0), idx[SYM_W-1:0]};
        l_we = 1'b1;
        k_we = 1'b1;
        f_we = 1'b1;
        if (idx == IDX_W'(ALPHA - 1)) begin
          state_next = pend ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        l_raddr = last;
        t_raddr = {SW'(s_tdata[16:8]), s_tdata[7:0]};
        if (in_ok) begin
          case (in_func)
            FUNC_RESET:    state_next = S_INIT;
            FUNC_APPEND:   state_next = is_full ? S_TG1 : S_LEN;
            FUNC_TRAVERSE: state_next = S_TR;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_LEN: begin
        l_we = 1'b1; l_waddr = cur; l_wdata = l_rdata + LW'(1);
        f_we = 1'b1; f_waddr = cur; f_wdata = FW'(l_rdata);
        state_next = S_CLR;
      end
      S_CLR: begin
        t_we = 1'b1; t_waddr = {cur, idx[SYM_W-1:0]};
        if (idx == IDX_W'(ALPHA - 1)) begin
          state_next = S_W1;
        end
      end
      S_W1: state_next = S_W2;
      S_W2: begin
        if (t_rdata != '0) begin
          state_next = S_Q1;
        end else begin
          t_we = 1'b1; t_wdata = cur;
          if (p == '0) begin
            k_we = 1'b1; k_waddr = cur; k_wdata = '0;
            state_next = S_TG1;
          end else begin
            state_next = S_W3;
          end
        end
      end
      S_W3: state_next = S_W1;
      S_Q1: begin
        l_raddr = p;
        state_next = S_Q2;
      end
      S_Q2: begin
        l_raddr = q; k_raddr = q; f_raddr = q;
        state_next = S_Q3;
      end
      S_Q3: begin
        l_raddr = q; k_raddr = q; f_raddr = q;
        if (lenp + LW'(1) == l_rdata) begin
          k_we = 1'b1; k_waddr = cur; k_wdata = q;
          state_next = S_TG1;
        end else begin
          l_we = 1'b1; l_waddr = SW'(count); l_wdata = lenp + LW'(1);
          k_we = 1'b1; k_waddr = SW'(count); k_wdata = k_rdata;
          f_we = 1'b1; f_waddr = SW'(count); f_wdata = f_rdata;
          state_next = S_CP;
        end
      end
      S_CP: begin
        t_raddr = {q, idx[SYM_W-1:0]};
        t_waddr = {cl, SYM_W'(idx - IDX_W'(1))};
        t_wdata = t_rdata;
        t_we    = (idx != '0);
        if (idx == IDX_W'(ALPHA)) begin
          state_next = S_R1;
        end
      end
      S_R1: state_next = S_R2;
      S_R2: begin
        if (t_rdata != q) begin
          state_next = S_L1;
        end else begin
          t_we = 1'b1; t_wdata = cl;
          state_next = (p == '0) ? S_L1 : S_R3;
        end
      end
      S_R3: state_next = S_R1;
      S_L1: begin
        k_we = 1'b1; k_waddr = cur; k_wdata = cl;
        state_next = S_L2;
      end
      S_L2: begin
        k_we = 1'b1; k_waddr = q; k_wdata = cl;
        state_next = S_TG1;
      end
      S_TR:  state_next = S_TG1;
      S_TG1: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CW'(1);
      symcount <= '0;
      last     <= '0;
      idx      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          idx <= idx + IDX_W'(1);
        end
        S_IDLE: begin
          if (in_ok) begin
            c     <= s_tdata[7:0];
            start <= s_tdata[16:8];
            full  <= 1'b0;
            tgt   <= '0;
            idx   <= '0;
            case (in_func)
              FUNC_RESET: begin
                count    <= CW'(1);
                symcount <= '0;
                last     <= '0;
                pend     <= 1'b1;
              end
              FUNC_APPEND: begin
                full <= is_full;
                tgt  <= last;
                cur  <= SW'(count);
              end
              default: ;
            endcase
          end
        end
        S_LEN: begin
          count    <= count + CW'(1);
          symcount <= symcount + LW'(1);
          p        <= last;
          last     <= cur;
          tgt      <= cur;
        end
        S_CLR: begin
          idx <= idx + IDX_W'(1);
        end
        S_W2: begin
          q <= t_rdata;
        end
        S_W3, S_R3: begin
          p <= k_rdata;
        end
        S_Q2: begin
          lenp <= l_rdata;
        end
        S_Q3: begin
          cl  <= SW'(count);
          idx <= '0;
          if (lenp + LW'(1) != l_rdata) begin
            count <= count + CW'(1);
          end
        end
        S_CP: begin
          idx <= idx + IDX_W'(1);
        end
        S_TR: begin
          tgt <= (32'(start) < 32'(count)) ? t_rdata : '0;
        end
        S_DONE: begin
          if (out_free) begin
            pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata[8:0]   <= 9'(tgt);
      m_tdata[17:9]  <= (tgt == '0) ? 9'd0 : 9'(l_rdata);
      m_tdata[25:18] <= (tgt == '0) ? 8'd0 : 8'(f_rdata);
      m_tdata[34:26] <= 9'(symcount);
      m_tdata[43:35] <= 9'(count);
      m_tdata[47:44] <= '0;
      m_tuser[0]     <= full;
    end
  end

endmodule
